>>> hdl/chxy_pkg.sv
// Shared types, constants and angle helpers for the compass heading block.
package chxy_pkg;

	// Angle resolution kept from the 32-bit accumulator, and rotation count
	localparam int ANGLE_BITS   = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_SIZE   = 24;
	localparam int STEPS        = (CORDIC_STEPS > TABLE_SIZE) ? TABLE_SIZE : CORDIC_STEPS;

	// Sample and datapath widths
	localparam int SAMPLE_W = 13;
	localparam int PRE_W    = SAMPLE_W + 1;
	localparam int FRAC_W   = 24;
	localparam int CW       = PRE_W + FRAC_W + 2;
	localparam int TURN_W   = 16;
	localparam int DEG_W    = 9;
	localparam int PROD_W   = TURN_W + DEG_W;

	localparam logic [DEG_W-1:0] DEG_PER_TURN = DEG_W'(360);
	localparam logic [31:0]      HALF_TURN    = 32'h8000_0000;

	// Shift amounts taking the accumulator to a 16-bit turn
	localparam int SH_DN = (ANGLE_BITS >= TURN_W) ? ANGLE_BITS - TURN_W : 0;
	localparam int SH_UP = (ANGLE_BITS < TURN_W) ? TURN_W - ANGLE_BITS : 0;

	// atan(2^-i) in units of 2^32 per turn, truncated
	localparam logic [31:0] ATAN_TURN [TABLE_SIZE] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	// One classified sample as it travels from front to back
	typedef struct packed {
		logic signed [PRE_W-1:0] x;
		logic signed [PRE_W-1:0] y;
		logic                    half;
		logic                    zero;
	} chxy_item_t;

	// Reduce the accumulator to a 16-bit binary angle
	function automatic logic [TURN_W-1:0] angle_to_turn(input logic [31:0] z);
		logic [31:0] a;
		a = z >> (32 - ANGLE_BITS);
		return TURN_W'((a >> SH_DN) << SH_UP);
	endfunction

endpackage

>>> hdl/compass_heading_from_xy.sv
// Compass heading top level: input stream, declination register, result stream.
//
// Use:
//   s_tdata carries one magnetometer sample pair (field_x, field_y); each item
//   accepted on s_tvalid && s_tready yields exactly one result on m_tdata:
//   heading_degrees (0..359, truncated) and heading_turn (65536 per turn),
//   equal to atan2(y, x) plus the declination, wrapped into one turn.
//   cfg_valid/cfg_data write the signed declination offset (binary angle
//   units); cfg_ready is always high. Write it only while the block is idle.
// Pipeline and throughput:
//   An accepted item passes through, in order: front
//   register, queue, load stage, 16 CORDIC micro-rotation stages, angle
//   stage, degree-multiply output register. One item per cycle sustained while
//   m_tready stays high; the rotation pipeline has one stage per micro-rotation.
// Reset:
//   arst_n clears all valid flags and the queue; the declination returns to
//   -70 units. No items are lost or created across a stall.
// Stall:
//   while m_tready is low on a held result, the pipeline holds; the four-entry queue
//   and front register keep accepting until full, then s_tready drops.
module compass_heading_from_xy (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // field_x[12:0], field_y[25:13], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // heading_degrees[8:0], heading_turn[24:9], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // declination_offset, signed
);
	import chxy_pkg::*;

	localparam logic [TURN_W-1:0] DECL_RESET = TURN_W'(-70);

	logic              fr_valid;
	logic              fifo_full;
	logic              fifo_empty;
	logic              fifo_pop;
	chxy_item_t        fr_item;
	chxy_item_t        fifo_item;
	logic [TURN_W-1:0] decl_q;
	logic [DEG_W-1:0]  deg;
	logic [TURN_W-1:0] turn;

	// Hold the declination register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= DECL_RESET;
		end else if (cfg_valid) begin
			decl_q <= cfg_data;
		end
	end

	chxy_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.item_valid (fr_valid),
		.item_ready (!fifo_full),
		.item       (fr_item)
	);

	chxy_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_valid),
		.push_item (fr_item),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.pop_item  (fifo_item),
		.empty     (fifo_empty)
	);

	chxy_cordic u_cordic (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_empty   (fifo_empty),
		.src_item    (fifo_item),
		.src_pop     (fifo_pop),
		.declination (decl_q),
		.res_valid   (m_tvalid),
		.res_ready   (m_tready),
		.res_degrees (deg),
		.res_turn    (turn)
	);

	// Pack the result item
	assign m_tdata = {7'b0, turn, deg};

endmodule

>>> hdl/chxy_front.sv
// Front end: takes sample pairs, folds the left half-plane and flags the origin.
module chxy_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [31:0]                in_data,   // field_x[12:0], field_y[25:13]
	output logic                       item_valid,
	input  logic                       item_ready,
	output chxy_pkg::chxy_item_t       item
);
	import chxy_pkg::*;

	logic signed [SAMPLE_W-1:0] fx;
	logic signed [SAMPLE_W-1:0] fy;
	logic signed [PRE_W-1:0]    ex;
	logic signed [PRE_W-1:0]    ey;
	chxy_item_t                 cls;
	logic                       vld_s1;
	chxy_item_t                 item_s1;

	// Classify the incoming pair
	always_comb begin
		fx       = in_data[SAMPLE_W-1:0];
		fy       = in_data[2*SAMPLE_W-1:SAMPLE_W];
		ex       = PRE_W'(fx);
		ey       = PRE_W'(fy);
		cls.half = fx[SAMPLE_W-1];
		cls.zero = (fx == '0) && (fy == '0);
		cls.x    = cls.half ? -ex : ex;
		cls.y    = cls.half ? -ey : ey;
	end

	assign in_ready   = !vld_s1 || item_ready;
	assign item_valid = vld_s1;
	assign item       = item_s1;

	// Hold the classified item until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

>>> hdl/chxy_fifo.sv
// Short queue between the front end and the rotation pipeline.
module chxy_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  chxy_pkg::chxy_item_t  push_item,
	output logic                  full,
	input  logic                  pop,
	output chxy_pkg::chxy_item_t  pop_item,
	output logic                  empty
);
	import chxy_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	chxy_item_t      mem [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [AW:0]     count_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (count_q == (AW+1)'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_item = mem[rd_ptr_q];

	// Store incoming items
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hdl/chxy_cordic.sv
// Back end: CORDIC vectoring pipeline, declination add and degree scaling.
module chxy_cordic (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       src_empty,
	input  chxy_pkg::chxy_item_t       src_item,
	output logic                       src_pop,
	input  logic [chxy_pkg::TURN_W-1:0] declination,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [chxy_pkg::DEG_W-1:0] res_degrees,
	output logic [chxy_pkg::TURN_W-1:0] res_turn
);
	import chxy_pkg::*;

	logic                 adv;
	logic                 vld_s   [STEPS+1];
	logic signed [CW-1:0] x_s     [STEPS+1];
	logic signed [CW-1:0] y_s     [STEPS+1];
	logic [31:0]          z_s     [STEPS+1];
	logic                 zero_s  [STEPS+1];
	logic                 vld_t_q;
	logic [TURN_W-1:0]    turn_t_q;
	logic [PROD_W-1:0]    prod;
	logic                 out_vld_q;
	logic [DEG_W-1:0]     deg_q;
	logic [TURN_W-1:0]    turn_q;

	// Whole pipeline moves when the output slot is free or being taken
	assign adv     = !out_vld_q || res_ready;
	assign src_pop = adv && !src_empty;

	// Load stage: scale samples into the fixed-point datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= !src_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (src_pop) begin
			x_s[0]    <= CW'($signed({src_item.x, {FRAC_W{1'b0}}}));
			y_s[0]    <= CW'($signed({src_item.y, {FRAC_W{1'b0}}}));
			z_s[0]    <= src_item.half ? HALF_TURN : 32'h0;
			zero_s[0] <= src_item.zero;
		end
	end

	// Micro-rotations, one per stage
	for (genvar i = 0; i < STEPS; i++) begin : g_rot
		logic signed [CW-1:0] xs;
		logic signed [CW-1:0] ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv && vld_s[i]) begin
				zero_s[i+1] <= zero_s[i];
				if (!y_s[i][CW-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= z_s[i] + ATAN_TURN[i];
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= z_s[i] - ATAN_TURN[i];
				end
			end
		end
	end

	// Reduce to a binary angle and add declination
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t_q <= 1'b0;
		end else if (adv) begin
			vld_t_q <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[STEPS]) begin
			turn_t_q <= (zero_s[STEPS] ? TURN_W'(0) : angle_to_turn(z_s[STEPS])) + declination;
		end
	end

	// Scale to degrees and hold the result for the receiver
	assign prod = PROD_W'(turn_t_q) * PROD_W'(DEG_PER_TURN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_t_q) begin
			deg_q  <= prod[PROD_W-1:TURN_W];
			turn_q <= turn_t_q;
		end
	end

	assign res_valid   = out_vld_q;
	assign res_degrees = deg_q;
	assign res_turn    = turn_q;

endmodule

>>> tb/tb_compass_heading_from_xy.sv
// Self-checking testbench for the compass heading block: CORDIC atan2 predictor and stream checks.
module tb_compass_heading_from_xy;
	timeunit 1ns;
	timeprecision 1ps;

	import chxy_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int PIPE_LATENCY = 20;
	localparam int HOLD_CYCLES  = 250;
	localparam int RANDOM_ITEMS = 1500;
	localparam int MAX_REPORTS  = 40;
	localparam logic [15:0] DECL_AT_RESET = 16'hFFBA;

	// Own copy of the arctangent table, 2^32 units per turn
	localparam logic [31:0] ARCTAN_UNITS [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};
	localparam int ROTATIONS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

	typedef struct packed {
		logic [8:0]  degrees;
		logic [15:0] turn;
	} heading_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // field_x[12:0], field_y[25:13], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // heading_degrees[8:0], heading_turn[24:9], zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	heading_t    heading_queue[$];
	logic [15:0] declination;
	int          mismatch_count;
	bit          no_gaps;
	bit          hold_req;

	compass_heading_from_xy uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Heading of one sample pair: CORDIC vectoring plus declination
	function automatic heading_t predict_heading(logic signed [12:0] fx, logic signed [12:0] fy,
			logic [15:0] decl);
		longint      x;
		longint      y;
		longint      xs;
		longint      ys;
		logic [31:0] z;
		logic [31:0] kept;
		logic [15:0] turn;
		logic [24:0] prod;
		heading_t    h;
		x = longint'(fx) * 64'sd16777216;
		y = longint'(fy) * 64'sd16777216;
		z = 32'd0;
		if (x != 0 || y != 0) begin
			// Left half-plane: rotate by half a turn first
			if (x < 0) begin
				x = -x;
				y = -y;
				z = 32'h8000_0000;
			end
			for (int i = 0; i < ROTATIONS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (y >= 0) begin
					x = x + ys;
					y = y - xs;
					z = z + ARCTAN_UNITS[i];
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - ARCTAN_UNITS[i];
				end
			end
		end
		kept = z >> (32 - ANGLE_BITS);
		if (ANGLE_BITS >= 16)
			turn = 16'(kept >> (ANGLE_BITS >= 16 ? ANGLE_BITS - 16 : 0));
		else
			turn = 16'(kept << (ANGLE_BITS < 16 ? 16 - ANGLE_BITS : 0));
		turn = turn + decl;
		prod = turn * 25'd360;
		h.degrees = prod[24:16];
		h.turn = turn;
		return h;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t: %s got %0d want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		heading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (heading_queue.size() == 0) begin
				report_mismatch("result with nothing pending, turn", m_tdata[24:9], -1);
			end else begin
				want = heading_queue.pop_front();
				if (m_tdata[8:0] !== want.degrees)
					report_mismatch("heading_degrees", m_tdata[8:0], want.degrees);
				if (m_tdata[24:9] !== want.turn)
					report_mismatch("heading_turn", m_tdata[24:9], want.turn);
				if (m_tdata[31:25] !== 7'd0)
					report_mismatch("pad bits", m_tdata[31:25], 0);
			end
		end
	end

	// Result side: random stalls, one long hold on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			m_tready <= no_gaps || ($urandom_range(99) >= 12);
		end
	end

	// Offer one sample pair and wait until it is taken
	task automatic send_sample(logic signed [12:0] fx, logic signed [12:0] fy);
		@(negedge clk);
		if (!no_gaps && $urandom_range(99) < 12) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, fy, fx};
		do @(posedge clk); while (!s_tready);
		heading_queue.push_back(predict_heading(fx, fy, declination));
	endtask

	// Drop valid and let the pipeline empty out
	task automatic settle_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (heading_queue.size() != 0) @(negedge clk);
		repeat (PIPE_LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_declination(logic [15:0] value);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		declination = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [12:0] random_field();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70)
			return 13'($urandom_range(8191));
		else if (pick < 85)
			return 13'($urandom_range(16) - 8);
		else
			case ($urandom_range(3))
				0: return 13'sd4095;
				1: return -13'sd4096;
				2: return 13'sd0;
				default: return 13'($urandom_range(2) - 1);
			endcase
	endfunction

	// Axis, diagonal and full-scale samples with the reset declination
	task automatic test_extremes();
		send_sample(13'sd0, 13'sd0);
		send_sample(13'sd4095, 13'sd0);
		send_sample(-13'sd4096, 13'sd0);
		send_sample(13'sd0, 13'sd4095);
		send_sample(13'sd0, -13'sd4096);
		send_sample(13'sd4095, 13'sd4095);
		send_sample(-13'sd4096, -13'sd4096);
		send_sample(-13'sd4096, 13'sd4095);
		send_sample(13'sd4095, -13'sd4096);
		send_sample(13'sd1, 13'sd0);
		send_sample(-13'sd1, 13'sd0);
		send_sample(13'sd0, 13'sd1);
		send_sample(13'sd0, -13'sd1);
		send_sample(-13'sd1, -13'sd1);
		send_sample(13'sd1, -13'sd1);
		send_sample(-13'sd1, 13'sd1);
		send_sample(-13'sd4096, 13'sd1);
		send_sample(-13'sd4096, -13'sd1);
		send_sample(13'sd4095, 13'sd1);
		send_sample(13'sd4095, -13'sd1);
	endtask

	// Zero sample gives the declination alone; sweep the register extremes
	task automatic test_declination();
		logic [15:0] settings [6];
		settings = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0000};
		settings[5] = 16'($urandom_range(65535));
		foreach (settings[k]) begin
			write_declination(settings[k]);
			send_sample(13'sd0, 13'sd0);
			send_sample(-13'sd4096, 13'sd0);
			send_sample(13'sd3, -13'sd2);
		end
	endtask

	// Random samples in phases, each with its own declination
	task automatic test_random_stream();
		for (int phase = 0; phase < 5; phase++) begin
			write_declination(phase == 0 ? DECL_AT_RESET : 16'($urandom_range(65535)));
			no_gaps = (phase == 2);
			repeat (RANDOM_ITEMS / 5) send_sample(random_field(), random_field());
			no_gaps = 1'b0;
		end
	endtask

	// Hold the result side long enough for the input to stall
	task automatic test_backpressure();
		settle_idle();
		no_gaps = 1'b1;
		hold_req = 1'b1;
		repeat (60) send_sample(random_field(), random_field());
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 32'd0;
		cfg_valid = 1'b0;
		cfg_data = 16'd0;
		declination = DECL_AT_RESET;
		mismatch_count = 0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		test_extremes();
		test_declination();
		test_random_stream();
		test_backpressure();
		settle_idle();

		if (mismatch_count == 0 && heading_queue.size() == 0)
			$display("compass_heading_from_xy: match");
		else
			$display("compass_heading_from_xy: mismatch");
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("compass_heading_from_xy: mismatch");
		$finish;
	end

endmodule

>>> compass_heading_from_xy.f
hdl/chxy_pkg.sv
hdl/chxy_front.sv
hdl/chxy_fifo.sv
hdl/chxy_cordic.sv
hdl/compass_heading_from_xy.sv
tb/tb_compass_heading_from_xy.sv
